### hdl/bspline_knot_span_table_macros.svh
// Assertion macros shared by the knot span table RTL.
`ifndef BSPLINE_KNOT_SPAN_TABLE_MACROS_SVH
`define BSPLINE_KNOT_SPAN_TABLE_MACROS_SVH

// Same-cycle implication, clocked on i_clk, held off while i_rst_n is low.
`define BKST_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, held off while i_rst_n is low.
`define BKST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

### hdl/bkst_pkg.sv
// Types and constants of the knot span table.
`default_nettype none
package bkst_pkg;

    localparam int VAL_W           = 17;
    localparam int OP_W            = 3;
    localparam int RES_IDX_W       = 6;
    localparam int STATUS_W        = 2;
    localparam int COUNT_OUT_W     = 7;

    localparam logic [VAL_W-1:0] KNOT_ZERO = 17'd0;
    localparam logic [VAL_W-1:0] KNOT_ONE  = 17'd65536;
    localparam int SPAN_MARGIN     = 2;
    localparam int MIN_VALID_KNOTS = 4;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_APPEND = 3'd1,
        OP_SPAN   = 3'd2,
        OP_INSERT = 3'd3,
        OP_CHECK  = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_ORDER = 2'd2,
        ST_FEW   = 2'd3
    } t_status;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] knot_value;
    } t_item;

    typedef struct packed {
        logic [RES_IDX_W-1:0]   result_index;
        logic [STATUS_W-1:0]    status;
        logic [COUNT_OUT_W-1:0] knot_count;
        logic                   is_valid;
    } t_result;

    typedef struct packed {
        logic load_val;
        logic load_prev;
    } t_cell_ctl;

    typedef struct packed {
        logic lt;
        logic le;
        logic desc;
    } t_cell_flag;

endpackage
`default_nettype wire

### hdl/bkst_cell.sv
// One knot cell: holds a knot, compares it with the operand and its left neighbour.
`default_nettype none
module bkst_cell import bkst_pkg::*; (
    input  logic             i_clk,
    input  logic             i_active,
    input  logic [VAL_W-1:0] i_val,
    input  logic [VAL_W-1:0] i_prev_knot,
    input  t_cell_ctl        i_ctl,
    output logic [VAL_W-1:0] o_knot,
    output t_cell_flag       o_flag
);

    logic [VAL_W-1:0] r_knot;
    logic [VAL_W-1:0] n_knot;

    always_comb begin
        priority if (i_ctl.load_val) begin
            n_knot = i_val;
        end else if (i_ctl.load_prev) begin
            n_knot = i_prev_knot;   // shift right by one place
        end else begin
            n_knot = r_knot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_knot <= n_knot;
    end

    always_comb begin
        o_flag.lt   = i_active && (r_knot < i_val);
        o_flag.le   = i_active && (r_knot <= i_val);
        o_flag.desc = i_active && (r_knot < i_prev_knot);
    end

    assign o_knot = r_knot;

endmodule
`default_nettype wire

### hdl/bspline_knot_span_table.sv
// Top level of the knot span table: command port, APB registers and the cell row.
`default_nettype none
`include "bspline_knot_span_table_macros.svh"
// Usage
// - Commands: drive i_item (op, knot_value) with start high; the beat is taken
//   at a rising edge where start is high and busy is low.
// - busy rises for the one execute cycle after a beat is taken. At the end of
//   that cycle every cell has compared its knot with the operand, the row
//   boundary is resolved, the cells shift or load, and the result registers.
// - o_done marks o_result for exactly one cycle, registered from busy after the
//   execute cycle; the receiver cannot stall and must take it then.
// - No new command is taken while busy is high, during the execute cycle of
//   the cell row and its boundary reduction.
// - Knots sit in a row of MAX_KNOTS cells kept sorted; insert shifts the cells
//   above the insert point one place to the right, each from its neighbour.
// - Registers over APB: curve_degree at address 0, match_tolerance at address 4.
//   Write them only while no command is in flight. pready is always high.
// - Reset (i_rst_n low, synchronous): knot count 0, degree 3, tolerance 1, no
//   command in flight. Knot cells are not cleared; only held knots are read.
module bspline_knot_span_table import bkst_pkg::*; #(
    parameter int MAX_KNOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_item       i_item,
    output logic        o_done,
    output t_result     o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W = $clog2(MAX_KNOTS + 1);
    localparam int IDX_W = $clog2(MAX_KNOTS);
    localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;
    localparam logic [3:0] DEG_RESET = 4'd3;
    localparam logic [7:0] TOL_RESET = 8'd1;
    localparam int REG_DEG = 0;

    // Configuration registers
    logic [3:0] r_deg;
    logic [7:0] r_tol;
    logic       cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg <= DEG_RESET;
            r_tol <= TOL_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == 1'(REG_DEG)) begin
                r_deg <= pwdata[3:0];
            end else begin
                r_tol <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == 1'(REG_DEG)) ? {28'd0, r_deg} : {24'd0, r_tol};

    // Command capture and control
    logic               r_busy;
    logic               r_done;
    logic [OP_W-1:0]    r_op;
    logic [VAL_W-1:0]   r_val;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    t_result            r_result;
    t_result            n_result;
    logic               accept;
    logic               do_append;
    logic               do_insert;

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= accept;
            r_done  <= r_busy;
            r_count <= n_count;
        end
    end

    // Payload: hold the operand beat and the result beat, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_item.op;
            r_val <= i_item.knot_value;
        end
        if (r_busy) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // Cell row
    logic [VAL_W-1:0] w_knot   [MAX_KNOTS];
    t_cell_flag       w_flag   [MAX_KNOTS];
    t_cell_ctl        w_ctl    [MAX_KNOTS];
    logic             w_active [MAX_KNOTS];
    logic [IDX_W-1:0] l_pos;

    for (genvar g = 0; g < MAX_KNOTS; g++) begin : g_cell
        logic [VAL_W-1:0] prev_knot;

        if (g == 0) begin : g_first
            assign prev_knot = KNOT_ZERO;   // nothing lies below the first cell
        end else begin : g_rest
            assign prev_knot = w_knot[g-1];
        end

        // A cell takes part in compares only while it holds a knot.
        assign w_active[g] = CNT_W'(g) < r_count;

        // Append loads the cell at the count; insert loads the cell at the
        // insert point and shifts every held cell above it one place right.
        always_comb begin
            w_ctl[g].load_val  = (do_append && (CNT_W'(g) == r_count)) ||
                                 (do_insert && (IDX_W'(g) == l_pos));
            w_ctl[g].load_prev = do_insert && (IDX_W'(g) > l_pos) &&
                                 (CNT_W'(g) <= r_count);
        end

        bkst_cell u_cell (
            .i_clk       (i_clk),
            .i_active    (w_active[g]),
            .i_val       (r_val),
            .i_prev_knot (prev_knot),
            .i_ctl       (w_ctl[g]),
            .o_knot      (w_knot[g]),
            .o_flag      (w_flag[g])
        );
    end

    // Boundary reduction. The row is sorted, so the lt and le flags form
    // thermometer codes; the single one-to-zero step gives the number
    // of knots below (l_pos) and at or below (m_pos) the operand.
    logic [IDX_W-1:0] m_pos;
    logic [VAL_W-1:0] k_at_l;
    logic [VAL_W-1:0] last_knot;
    logic             desc_any;

    always_comb begin
        l_pos     = '0;
        m_pos     = '0;
        k_at_l    = '0;
        last_knot = '0;
        desc_any  = 1'b0;
        for (int i = 1; i < MAX_KNOTS; i++) begin
            if (w_flag[i-1].lt && !w_flag[i].lt) begin
                l_pos  = l_pos | IDX_W'(i);
                k_at_l = k_at_l | w_knot[i];
            end
            if (w_flag[i-1].le && !w_flag[i].le) begin
                m_pos = m_pos | IDX_W'(i);
            end
        end
        for (int i = 0; i < MAX_KNOTS - 1; i++) begin
            if (w_active[i] && !w_active[i+1]) begin
                last_knot = last_knot | w_knot[i];
            end
        end
        if (w_active[MAX_KNOTS-1]) begin
            last_knot = last_knot | w_knot[MAX_KNOTS-1];
        end
        for (int i = 0; i < MAX_KNOTS; i++) begin
            desc_any = desc_any | w_flag[i].desc;
        end
    end

    // Execute: decide status, index and the row update
    logic             full;
    logic [VAL_W-1:0] diff;

    assign full = r_count == CNT_W'(MAX_KNOTS);
    assign diff = (k_at_l >= r_val) ? (k_at_l - r_val) : (r_val - k_at_l);

    always_comb begin
        n_count   = r_count;
        do_append = 1'b0;
        do_insert = 1'b0;
        n_result  = '0;
        if (r_busy) begin
            unique case (r_op)
                OP_CLEAR: begin
                    n_count = '0;
                end
                OP_APPEND: begin
                    priority if (full) begin
                        n_result.status = ST_FULL;
                    end else if (r_val > KNOT_ONE) begin
                        n_result.status = ST_ORDER;
                    end else if ((r_count != '0) && (r_val < last_knot)) begin
                        n_result.status = ST_ORDER;
                    end else begin
                        do_append = 1'b1;
                        n_count   = r_count + CNT_W'(1);
                    end
                end
                OP_SPAN: begin
                    priority if (CMP_W'(r_count) < CMP_W'(r_deg) + CMP_W'(SPAN_MARGIN)) begin
                        n_result.status = ST_FEW;
                    end else if (r_val >= last_knot) begin
                        n_result.result_index = RES_IDX_W'(CMP_W'(r_count) - CMP_W'(r_deg)
                                                           - CMP_W'(SPAN_MARGIN));
                    end else if (r_val <= w_knot[0]) begin
                        n_result.result_index = RES_IDX_W'(r_deg);
                    end else if (diff <= VAL_W'(r_tol)) begin
                        n_result.result_index = RES_IDX_W'(CMP_W'(m_pos) - CMP_W'(1));
                    end else begin
                        n_result.result_index = RES_IDX_W'(CMP_W'(l_pos) - CMP_W'(1));
                    end
                end
                OP_INSERT: begin
                    priority if ((r_val == KNOT_ZERO) || (r_val >= KNOT_ONE)) begin
                        n_result.status = ST_ORDER;
                    end else if (full) begin
                        n_result.status = ST_FULL;
                    end else if (l_pos == '0) begin
                        n_result.status = ST_ORDER;
                    end else begin
                        do_insert = 1'b1;
                        n_count   = r_count + CNT_W'(1);
                        n_result.result_index = RES_IDX_W'(CMP_W'(l_pos) - CMP_W'(1));
                    end
                end
                OP_CHECK: begin
                    if (CMP_W'(r_count) < CMP_W'(MIN_VALID_KNOTS)) begin
                        n_result.status = ST_FEW;
                    end else begin
                        n_result.is_valid = (w_knot[0] == KNOT_ZERO) &&
                                            (last_knot == KNOT_ONE) && !desc_any;
                    end
                end
                default: begin
                    // unused op codes: no change, status ok
                end
            endcase
            n_result.knot_count = COUNT_OUT_W'(n_count);
        end
    end

    // Assertions
    `BKST_ASSERT_IMPL(a_done_follows_accept, start && !busy, ##2 o_done, "no result after command")
    `BKST_ASSERT_NEXT(a_busy_one_cycle, busy, !busy && o_done, "execute cycle overran")
    `BKST_ASSERT_IMPL(a_done_not_busy, o_done, !busy, "result beat while busy")
    `BKST_ASSERT_IMPL(a_err_index_zero, o_done && (o_result.status != ST_OK),
                      o_result.result_index == '0, "nonzero index with error status")

endmodule
`default_nettype wire
